[hdl/btda_pkg.sv]
// shared constants, types and controller states of the binary to decimal ascii converter
package btda_pkg;

	localparam int VALUE_WIDTH = 64;
	// decimal digits needed for VALUE_WIDTH bits: floor(w * log10(2)) + 1
	localparam int NUM_DIGITS  = (VALUE_WIDTH * 30103) / 100000 + 1;
	localparam int DIG_IW      = $clog2(NUM_DIGITS);
	localparam int CNT_W       = $clog2(NUM_DIGITS + 1);
	localparam int STEP_W      = $clog2(VALUE_WIDTH);

	localparam logic [5:0] ASCII_ZERO = 6'd48;
	localparam logic [3:0] BCD_ADJ_MIN = 4'd5;
	localparam logic [3:0] BCD_ADJ = 4'd3;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic load;
		logic shift;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic out_free;
		logic emit_last;
	} sts_t;

endpackage

[hdl/btda_ctrl.sv]
// controller state machine: accept, shift sequencing and digit emission
module btda_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  btda_pkg::sts_t sts,
	output btda_pkg::cmd_t cmd
);
	import btda_pkg::*;

	state_t            state_q, state_d;
	logic [STEP_W-1:0] step_q, step_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		step_d   = step_q;
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					step_d   = STEP_W'(VALUE_WIDTH - 1);
					state_d  = ST_CONV;
				end
			end
			ST_CONV: begin
				cmd.shift = 1'b1;
				if (step_q == '0) begin
					state_d = ST_EMIT;
				end else begin
					step_d = step_q - 1'b1;
				end
			end
			ST_EMIT: begin
				// one digit per free slot in the output register
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					if (sts.emit_last) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

[hdl/btda_datapath.sv]
// datapath: serial double-dabble registers, digit count tracking and output register
module btda_datapath (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [63:0]    value,
	input  btda_pkg::cmd_t cmd,
	output btda_pkg::sts_t sts,
	output logic           out_valid,
	input  logic           out_stall,
	output logic [5:0]     digit_char,
	output logic           is_last,
	output logic [4:0]     digit_count
);
	import btda_pkg::*;

	logic [VALUE_WIDTH-1:0]      bin_q;
	logic [NUM_DIGITS-1:0][3:0]  bcd_q;
	logic [NUM_DIGITS-1:0][3:0]  bcd_adj;
	logic [NUM_DIGITS-1:0][3:0]  bcd_next;
	logic [DIG_IW-1:0]           top_q;
	logic [CNT_W-1:0]            ndig_q;
	logic                        grow;
	logic [DIG_IW-1:0]           top_up;
	logic                        out_valid_q;
	logic [5:0]                  char_q;
	logic                        last_q;
	logic [4:0]                  count_q;

	always_comb begin
		for (int i = 0; i < NUM_DIGITS; i++) begin
			bcd_adj[i] = (bcd_q[i] >= BCD_ADJ_MIN) ? bcd_q[i] + BCD_ADJ : bcd_q[i];
		end
	end

	// the top digit never reaches 8, so its msb can be dropped on the shift
	assign bcd_next = {bcd_adj[NUM_DIGITS-1][2:0], bcd_adj[NUM_DIGITS-2:0],
		bin_q[VALUE_WIDTH-1]};

	// the value at most doubles plus one per step, so at most one new digit appears
	assign top_up = top_q + 1'b1;
	assign grow   = (top_q != DIG_IW'(NUM_DIGITS - 1)) && (bcd_next[top_up] != 4'd0);

	assign sts.out_free  = !out_valid_q || !out_stall;
	assign sts.emit_last = (top_q == '0);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			bin_q  <= value[VALUE_WIDTH-1:0];
			bcd_q  <= '0;
			top_q  <= '0;
			ndig_q <= CNT_W'(1);
		end else if (cmd.shift) begin
			bin_q <= {bin_q[VALUE_WIDTH-2:0], 1'b0};
			bcd_q <= bcd_next;
			if (grow) begin
				top_q  <= top_up;
				ndig_q <= ndig_q + 1'b1;
			end
		end else if (cmd.emit) begin
			top_q <= top_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			char_q  <= ASCII_ZERO + {2'b00, bcd_q[top_q]};
			last_q  <= sts.emit_last;
			count_q <= sts.emit_last ? 5'(ndig_q) : 5'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid   = out_valid_q;
	assign digit_char  = char_q;
	assign is_last     = last_q;
	assign digit_count = count_q;

endmodule

[hdl/binary_to_decimal_ascii.sv]
// top level of the binary to decimal ascii converter
//
// converts one unsigned binary value into its decimal text, one ascii digit
// per output transaction, most significant digit first, no leading zeros.
// zero gives the single digit '0'. the last digit has is_last set and
// carries digit_count, the number of digits in the run; other digits show 0.
// input channel: in_valid / in_stall with value; in_stall is low only while
// the block is idle, so one value is converted at a time.
// output channel: out_valid / out_stall with digit_char, is_last, digit_count
// from an output register; a stalled digit holds until taken.
// steps: an accept, then VALUE_WIDTH serial double-dabble shifts
// (64 by default, one bit per cycle through the bcd register), then the
// digits, one per cycle when the receiver does not stall. the next value
// is taken while the last digit still waits.
// bits of value above VALUE_WIDTH are ignored.
// reset clears the controller and the output valid flag; nothing else
// needs clearing. receiver stalls only delay the digit emission.
module binary_to_decimal_ascii (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [63:0] value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [5:0]  digit_char,
	output logic        is_last,
	output logic [4:0]  digit_count
);
	import btda_pkg::*;

	cmd_t cmd;
	sts_t sts;

	btda_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	btda_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.value       (value),
		.cmd         (cmd),
		.sts         (sts),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.digit_char  (digit_char),
		.is_last     (is_last),
		.digit_count (digit_count)
	);

endmodule
